### rtl/core/slfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab free-list package
// Shared constants, result codes and the control/status types that join the
// controller and the datapath of the slab free-list manager.
// ----------------------------------------------------------------------------
package slfl_pkg;

	localparam int BLOCK_BYTES = 16384;
	localparam int ADDR_W      = $clog2(BLOCK_BYTES);
	localparam int LINK_W      = ADDR_W + 1;
	localparam int SIZE_W      = 15;
	localparam int CNT_W       = 15;
	localparam int OFS_IN_W    = 16;
	localparam int SUM_W       = SIZE_W + 1;

	localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(2);
	localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(16);

	// Link word: top bit marks end of list, low bits hold the next offset.
	localparam logic [LINK_W-1:0] NULL_LINK = {1'b1, {ADDR_W{1'b0}}};

	localparam logic [1:0] REQ_FORMAT = 2'd0;
	localparam logic [1:0] REQ_ALLOC  = 2'd1;
	localparam logic [1:0] REQ_FREE   = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	localparam logic [1:0] NOTIFY_NONE  = 2'd0;
	localparam logic [1:0] NOTIFY_EMPTY = 2'd1;
	localparam logic [1:0] NOTIFY_LOW   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FMT,
		ST_ALLOC
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_FMT_NONE,
		OP_FMT_BEGIN,
		OP_FMT_STEP,
		OP_ALLOC_FAIL,
		OP_ALLOC_RD,
		OP_ALLOC_DONE,
		OP_FREE,
		OP_RANGE_ERR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic fmt_none;
		logic fmt_last;
		logic alloc_empty;
		logic free_oor;
	} sts_t;

endpackage

### rtl/core/slfl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab free-list controller
// Decodes accepted transactions and sequences format walks and the
// allocate (read, then completion) through the datapath.
// ----------------------------------------------------------------------------
module slfl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      req_type,
	input  slfl_pkg::sts_t  sts,
	output slfl_pkg::cmd_t  cmd,
	output logic            busy
);
	import slfl_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_FORMAT && !sts.fmt_none) begin
						state_nxt = ST_FMT;
					end else if (req_type == REQ_ALLOC && !sts.alloc_empty) begin
						state_nxt = ST_ALLOC;
					end
				end
			end
			ST_FMT: begin
				if (sts.fmt_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_ALLOC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		busy   = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_FORMAT: cmd.op = sts.fmt_none ? OP_FMT_NONE : OP_FMT_BEGIN;
						REQ_ALLOC:  cmd.op = sts.alloc_empty ? OP_ALLOC_FAIL : OP_ALLOC_RD;
						REQ_FREE:   cmd.op = sts.free_oor ? OP_RANGE_ERR : OP_FREE;
						default:    cmd.op = OP_NOP;
					endcase
				end
			end
			ST_FMT:   cmd.op = OP_FMT_STEP;
			ST_ALLOC: cmd.op = OP_ALLOC_DONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	a_alloc_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC |=> state_q == ST_IDLE)
		else $error("allocate held the controller beyond its read cycle");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> cmd.op == OP_FMT_STEP || cmd.op == OP_ALLOC_DONE)
		else $error("controller issued a request command while busy");

	a_fmt_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FMT_BEGIN |=> state_q == ST_FMT)
		else $error("format walk did not start");

endmodule

### rtl/core/slfl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab free-list datapath
// Link memory, list heads, live and slot counters, format walker and the
// registered result.
// ----------------------------------------------------------------------------
module slfl_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  slfl_pkg::cmd_t                 cmd,
	output slfl_pkg::sts_t                 sts,
	input  logic                           cfg_we,
	input  logic [slfl_pkg::SIZE_W-1:0]    cfg_wdata,
	input  logic [slfl_pkg::OFS_IN_W-1:0]  offset_in,
	input  logic                           from_owner,
	input  logic                           block_active,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [slfl_pkg::ADDR_W-1:0]    offset_out,
	output logic [1:0]                     notify
);
	import slfl_pkg::*;

	logic [LINK_W-1:0] link_mem [BLOCK_BYTES];
	logic [LINK_W-1:0] rd_data_q;

	logic [SIZE_W-1:0] obj_size_q;
	logic [ADDR_W-1:0] owner_head_q;
	logic              owner_vld_q;
	logic [ADDR_W-1:0] foreign_head_q;
	logic              foreign_vld_q;
	logic [CNT_W-1:0]  live_q;
	logic [CNT_W-1:0]  slots_q;
	logic [ADDR_W-1:0] fmt_addr_q;

	logic              done_q;
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] offset_out_q;
	logic [1:0]        notify_q;

	logic [SIZE_W-1:0] size_eff;
	logic [SUM_W-1:0]  fmt_next;
	logic [SUM_W-1:0]  fmt_after;
	logic [ADDR_W-1:0] free_ofs;
	logic              sel_vld;
	logic [ADDR_W-1:0] sel_head;
	logic [CNT_W-1:0]  live_dec;
	logic [1:0]        free_notify;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [LINK_W-1:0] wr_data;

	assign size_eff  = (obj_size_q < SIZE_MIN) ? SIZE_MIN : obj_size_q;
	assign fmt_next  = SUM_W'(fmt_addr_q) + SUM_W'(size_eff);
	assign fmt_after = fmt_next + SUM_W'(size_eff);
	assign free_ofs  = offset_in[ADDR_W-1:0];
	assign sel_vld   = from_owner ? owner_vld_q : foreign_vld_q;
	assign sel_head  = from_owner ? owner_head_q : foreign_head_q;
	assign live_dec  = (live_q == '0) ? '0 : live_q - CNT_W'(1);
	assign rd_addr   = owner_vld_q ? owner_head_q : foreign_head_q;

	assign sts.fmt_none    = (size_eff > SIZE_W'(BLOCK_BYTES));
	// Close the chain when the following slot would not fit in the block.
	assign sts.fmt_last    = (fmt_after > SUM_W'(BLOCK_BYTES));
	assign sts.alloc_empty = !owner_vld_q && !foreign_vld_q;
	assign sts.free_oor    = (offset_in >= OFS_IN_W'(BLOCK_BYTES));

	always_comb begin
		priority if (block_active) begin
			free_notify = NOTIFY_NONE;
		end else if (live_dec == '0) begin
			free_notify = NOTIFY_EMPTY;
		end else if (live_dec <= (slots_q >> 2)) begin
			free_notify = NOTIFY_LOW;
		end else begin
			free_notify = NOTIFY_NONE;
		end
	end

	// One write port, shared by the format walk and free.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fmt_addr_q;
		wr_data = NULL_LINK;
		if (cmd.op == OP_FMT_STEP) begin
			wr_en   = 1'b1;
			wr_data = sts.fmt_last ? NULL_LINK : {1'b0, fmt_next[ADDR_W-1:0]};
		end else if (cmd.op == OP_FREE) begin
			wr_en   = 1'b1;
			wr_addr = free_ofs;
			wr_data = sel_vld ? {1'b0, sel_head} : NULL_LINK;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (cmd.op == OP_ALLOC_RD) begin
			rd_data_q <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_size_q     <= SIZE_RST;
			owner_head_q   <= '0;
			owner_vld_q    <= 1'b0;
			foreign_head_q <= '0;
			foreign_vld_q  <= 1'b0;
			live_q         <= '0;
			slots_q        <= '0;
			fmt_addr_q     <= '0;
			done_q         <= 1'b0;
			status_q       <= STATUS_OK;
			offset_out_q   <= '0;
			notify_q       <= NOTIFY_NONE;
		end else begin
			if (cfg_we) begin
				obj_size_q <= cfg_wdata;
			end
			done_q       <= 1'b0;
			status_q     <= STATUS_OK;
			offset_out_q <= '0;
			notify_q     <= NOTIFY_NONE;
			unique case (cmd.op)
				OP_FMT_NONE: begin
					owner_head_q   <= '0;
					owner_vld_q    <= 1'b0;
					foreign_head_q <= '0;
					foreign_vld_q  <= 1'b0;
					live_q         <= '0;
					slots_q        <= '0;
					done_q         <= 1'b1;
				end
				OP_FMT_BEGIN: begin
					owner_head_q   <= '0;
					owner_vld_q    <= 1'b1;
					foreign_head_q <= '0;
					foreign_vld_q  <= 1'b0;
					live_q         <= '0;
					slots_q        <= '0;
					fmt_addr_q     <= '0;
				end
				OP_FMT_STEP: begin
					slots_q    <= slots_q + CNT_W'(1);
					fmt_addr_q <= fmt_next[ADDR_W-1:0];
					done_q     <= sts.fmt_last;
				end
				OP_ALLOC_FAIL: begin
					status_q <= STATUS_EMPTY;
					done_q   <= 1'b1;
				end
				OP_ALLOC_RD: begin
					// Take over the foreign list when the owner list has run dry.
					if (!owner_vld_q) begin
						owner_head_q   <= foreign_head_q;
						owner_vld_q    <= foreign_vld_q;
						foreign_head_q <= '0;
						foreign_vld_q  <= 1'b0;
					end
				end
				OP_ALLOC_DONE: begin
					if (rd_data_q[LINK_W-1]) begin
						owner_head_q <= '0;
						owner_vld_q  <= 1'b0;
					end else begin
						owner_head_q <= rd_data_q[ADDR_W-1:0];
					end
					if (live_q != COUNT_MAX) begin
						live_q <= live_q + CNT_W'(1);
					end
					offset_out_q <= owner_head_q;
					done_q       <= 1'b1;
				end
				OP_FREE: begin
					if (from_owner) begin
						owner_head_q <= free_ofs;
						owner_vld_q  <= 1'b1;
					end else begin
						foreign_head_q <= free_ofs;
						foreign_vld_q  <= 1'b1;
					end
					live_q   <= live_dec;
					notify_q <= free_notify;
					done_q   <= 1'b1;
				end
				OP_RANGE_ERR: begin
					status_q <= STATUS_RANGE;
					done_q   <= 1'b1;
				end
				OP_NOP: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign offset_out = offset_out_q;
	assign notify     = notify_q;

	a_alloc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_ALLOC_RD |=> cmd.op == OP_ALLOC_DONE)
		else $error("allocate read not followed by its completion");

	a_alloc_valid_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_ALLOC_DONE |-> owner_vld_q)
		else $error("allocate completing on an empty owner list");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != STATUS_OK |-> notify_q == NOTIFY_NONE && offset_out_q == '0)
		else $error("failed transaction carries offset or notification");

	a_free_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FREE |=> owner_vld_q || foreign_vld_q)
		else $error("free left both lists empty");

endmodule

### rtl/core/slab_free_list_manager_unit.sv
`timescale 1ns / 1ps
// Latency: free, range error and unused codes are busy-free; the result strobes the next cycle.
// Allocate: busy for one cycle; the link-memory read is registered, then the result.
// Format: busy while the walk writes the slots (BLOCK_BYTES / slot size, rounded down), one
//   link write per cycle; the result strobes the cycle after the last write.
// Results are registered and shown for one cycle; the receiver cannot stall.
// Reset: lists empty, counts zero, slot size 16; link memory is not cleared.
// ----------------------------------------------------------------------------
// Slab free-list manager
// Owner and foreign free lists of fixed-size slots in one block, with format,
// allocate and free transactions.
// ----------------------------------------------------------------------------
module slab_free_list_manager_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     req_type,
	input  logic [slfl_pkg::OFS_IN_W-1:0]  offset_in,
	input  logic                           from_owner,
	input  logic                           block_active,
	input  logic                           cfg_we,
	input  logic [slfl_pkg::SIZE_W-1:0]    cfg_wdata,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [slfl_pkg::ADDR_W-1:0]    offset_out,
	output logic [1:0]                     notify
);
	import slfl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	slfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	slfl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.offset_in    (offset_in),
		.from_owner   (from_owner),
		.block_active (block_active),
		.done         (done),
		.status       (status),
		.offset_out   (offset_out),
		.notify       (notify)
	);

endmodule
